// ===== hw/rtl/modexp_pkg.sv =====
package modexp_pkg;

  // Default word width of the base, the modulus, the exponent and the result.
  localparam int WORD_BITS = 32;

  // Register values after reset.
  localparam int MODULUS_RESET  = 17;
  localparam int EXPONENT_RESET = 6;

  // Configuration register indexes.
  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MODULUS  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_EXPONENT = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // take a new base, start reducing it, set the power to one
    logic start_sq;   // start squaring the running power
    logic start_mb;   // start multiplying the running power by the reduced base
    logic step;       // one double-and-add step of the modular product
    logic save_base;  // keep the finished product as the reduced base
    logic save_acc;   // keep the finished product as the running power
    logic exp_shift;  // move to the next exponent bit
    logic write_out;  // load the result register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic exp_msb;    // current exponent bit
    logic out_busy;   // result register holds a request that is stalled
  } dp_status_t;

endpackage

// ===== hw/rtl/modexp_dp.sv =====
module modexp_dp #(
  parameter int WORD_BITS = modexp_pkg::WORD_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  modexp_pkg::dp_cmd_t    cmd,
  output modexp_pkg::dp_status_t status,
  input  logic [WORD_BITS-1:0]   base,
  input  logic [WORD_BITS-1:0]   modulus,
  input  logic [WORD_BITS-1:0]   exponent,
  output logic [WORD_BITS-1:0]   power_mod,
  output logic                   out_valid,
  input  logic                   out_stall
);

  logic [WORD_BITS-1:0] mul_x;
  logic [WORD_BITS-1:0] mul_y;
  logic [WORD_BITS-1:0] prod;
  logic [WORD_BITS-1:0] prod_next;
  logic [WORD_BITS-1:0] base_red;
  logic [WORD_BITS-1:0] acc;
  logic [WORD_BITS-1:0] exp_sh;
  logic [WORD_BITS+1:0] addend;
  logic [WORD_BITS+1:0] sum;
  logic [WORD_BITS+1:0] mod_1x;
  logic [WORD_BITS+1:0] mod_2x;
  logic [WORD_BITS+1:0] sum_red;
  logic                 small_mod;

  // One double-and-add step: 2*prod + x*bit lies below 3n, so at most one
  // of n or 2n has to come off.
  always_comb begin
    addend  = mul_y[WORD_BITS-1] ? {2'b00, mul_x} : '0;
    sum     = {1'b0, prod, 1'b0} + addend;
    mod_1x  = {2'b00, modulus};
    mod_2x  = {1'b0, modulus, 1'b0};
    if (sum >= mod_2x) begin
      sum_red = sum - mod_2x;
    end else if (sum >= mod_1x) begin
      sum_red = sum - mod_1x;
    end else begin
      sum_red = sum;
    end
    prod_next = sum_red[WORD_BITS-1:0];
  end

  // A modulus of zero or one leaves only the residue zero.
  assign small_mod = (modulus[WORD_BITS-1:1] == '0);

  // Operand, product, power and exponent registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mul_x  <= WORD_BITS'(1);
      mul_y  <= base;
      prod   <= '0;
      acc    <= WORD_BITS'(1);
      exp_sh <= exponent;
    end
    if (cmd.start_sq) begin
      mul_x <= acc;
      mul_y <= acc;
      prod  <= '0;
    end
    if (cmd.start_mb) begin
      mul_x <= acc;
      mul_y <= base_red;
      prod  <= '0;
    end
    if (cmd.step) begin
      prod  <= prod_next;
      mul_y <= {mul_y[WORD_BITS-2:0], 1'b0};
    end
    if (cmd.save_base) begin
      base_red <= prod_next;
    end
    if (cmd.save_acc) begin
      acc <= prod_next;
    end
    if (cmd.exp_shift) begin
      exp_sh <= {exp_sh[WORD_BITS-2:0], 1'b0};
    end
    if (cmd.write_out) begin
      power_mod <= small_mod ? '0 : acc;
    end
  end

  // Result request valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.write_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign status.exp_msb  = exp_sh[WORD_BITS-1];
  assign status.out_busy = out_valid && out_stall;

endmodule

// ===== hw/rtl/modexp_ctrl.sv =====
module modexp_ctrl #(
  parameter int WORD_BITS = modexp_pkg::WORD_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  output modexp_pkg::dp_cmd_t    cmd,
  input  modexp_pkg::dp_status_t status
);

  localparam int CNT_BITS = $clog2(WORD_BITS);
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WORD_BITS - 1);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_REDUCE   = 3'd1;
  localparam logic [2:0] ST_SQ_SETUP = 3'd2;
  localparam logic [2:0] ST_SQ       = 3'd3;
  localparam logic [2:0] ST_MB_SETUP = 3'd4;
  localparam logic [2:0] ST_MB       = 3'd5;
  localparam logic [2:0] ST_FINISH   = 3'd6;

  logic [2:0]          state;
  logic [2:0]          state_next;
  logic [CNT_BITS-1:0] cnt;
  logic [CNT_BITS-1:0] cnt_next;
  logic [CNT_BITS-1:0] ecnt;
  logic [CNT_BITS-1:0] ecnt_next;
  logic                bit_done;

  // Next state, counters and datapath commands.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    ecnt_next  = ecnt;
    cmd        = '0;
    bit_done   = 1'b0;
    in_stall   = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          cnt_next   = CNT_LAST;
          state_next = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        cmd.step = 1'b1;
        if (cnt == '0) begin
          cmd.save_base = 1'b1;
          ecnt_next     = CNT_LAST;
          state_next    = ST_SQ_SETUP;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      ST_SQ_SETUP: begin
        cmd.start_sq = 1'b1;
        cnt_next     = CNT_LAST;
        state_next   = ST_SQ;
      end
      ST_SQ: begin
        cmd.step = 1'b1;
        if (cnt == '0) begin
          cmd.save_acc = 1'b1;
          if (status.exp_msb) begin
            state_next = ST_MB_SETUP;
          end else begin
            bit_done = 1'b1;
          end
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      ST_MB_SETUP: begin
        cmd.start_mb = 1'b1;
        cnt_next     = CNT_LAST;
        state_next   = ST_MB;
      end
      ST_MB: begin
        cmd.step = 1'b1;
        if (cnt == '0) begin
          cmd.save_acc = 1'b1;
          bit_done     = 1'b1;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      ST_FINISH: begin
        if (!status.out_busy) begin
          cmd.write_out = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // Move on to the next exponent bit, or finish after the last one.
    if (bit_done) begin
      cmd.exp_shift = 1'b1;
      if (ecnt == '0) begin
        state_next = ST_FINISH;
      end else begin
        ecnt_next  = ecnt - 1'b1;
        state_next = ST_SQ_SETUP;
      end
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      ecnt  <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      ecnt  <= ecnt_next;
    end
  end

endmodule

// ===== hw/rtl/modular_exponentiation.sv =====
// Sequence: the request is taken and the base is reduced, then per exponent bit the power is
// squared and, where the bit is set, multiplied by the reduced base; last the result register
// is loaded.
// Throughput: one item at a time on a single bit-serial modular multiplier; the next request
// is taken once the result is loaded, even while that result still waits in the register.
// Reset (synchronous, active high) sets the modulus to 17, the exponent to 6, idles the core.
module modular_exponentiation #(
  parameter int WORD_BITS = modexp_pkg::WORD_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [modexp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [WORD_BITS-1:0]                cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [WORD_BITS-1:0]                base,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [WORD_BITS-1:0]                power_mod
);

  logic [WORD_BITS-1:0]   modulus;
  logic [WORD_BITS-1:0]   exponent;
  modexp_pkg::dp_cmd_t    cmd;
  modexp_pkg::dp_status_t status;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus  <= WORD_BITS'(modexp_pkg::MODULUS_RESET);
      exponent <= WORD_BITS'(modexp_pkg::EXPONENT_RESET);
    end else if (cfg_write) begin
      case (cfg_index)
        modexp_pkg::REG_MODULUS:  modulus  <= cfg_data;
        modexp_pkg::REG_EXPONENT: exponent <= cfg_data;
        default: ;
      endcase
    end
  end

  modexp_ctrl #(
    .WORD_BITS(WORD_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  modexp_dp #(
    .WORD_BITS(WORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .base      (base),
    .modulus   (modulus),
    .exponent  (exponent),
    .power_mod (power_mod),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

  // A new base is loaded only on an accepted request.
  assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (in_valid && !in_stall))
    else $error("base loaded without an accepted request");

  // After a request is taken the core is busy in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("core not busy after accepting a request");

  // The result register is never overwritten while its request is stalled.
  assert property (@(posedge clk) disable iff (rst)
    cmd.write_out |-> !(out_valid && out_stall))
    else $error("result overwritten while stalled");

  // Every delivered result is a proper residue of a modulus above one.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (modulus > WORD_BITS'(1))) |-> (power_mod < modulus))
    else $error("result not reduced below the modulus");

endmodule

// ===== bench/tb_modular_exponentiation.sv =====
module tb_modular_exponentiation;

  localparam int W = modexp_pkg::WORD_BITS;
  localparam int DIRECTED = 22;
  localparam int RANDOM_REQUESTS = 268;
  // One item at its slowest: base reduction plus a square and a multiply per exponent bit.
  localparam int SETTLE_CYCLES = (W + 3) + 2 * W * (W + 1) + 64;
  localparam int STUCK_LIMIT = 40000;
  localparam int REPORT_LIMIT = 10;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [modexp_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [W-1:0] base;
  logic out_valid;
  logic out_stall;
  logic [W-1:0] power_mod;

  // Directed stimulus: the core settings, the base, and a hand-worked answer where one is obvious.
  typedef struct packed {
    logic [W-1:0] modulus;
    logic [W-1:0] exponent;
    logic [W-1:0] base;
    logic known;
    logic [W-1:0] power;
  } probe_t;

  probe_t probes [0:DIRECTED-1];

  // Shadow copy of the core settings, updated with every register write.
  logic [W-1:0] mod_cfg;
  logic [W-1:0] exp_cfg;

  // Answer for the request now on the input port; it moves into the queue on acceptance.
  logic [W-1:0] want_power;
  logic [W-1:0] power_due [$];

  int fault_count;
  int stuck_cycles;
  int hold_cycles;
  bit steady;

  modular_exponentiation u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .base      (base),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .power_mod (power_mod)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Square-and-multiply with exact 64-bit products; a zero modulus gives zero.
  function automatic logic [W-1:0] modpow(logic [W-1:0] b, logic [W-1:0] e,
                                          logic [W-1:0] n);
    longint unsigned acc;
    longint unsigned bb;
    longint unsigned nn;
    if (n == '0) return '0;
    nn = n;
    bb = b % nn;
    acc = 1 % nn;
    for (int i = W - 1; i >= 0; i--) begin
      acc = (acc * acc) % nn;
      if (e[i]) acc = (acc * bb) % nn;
    end
    return acc[W-1:0];
  endfunction

  // Moduli lean toward the edges: tiny, all ones, top bit set, and the degenerate 0 and 1.
  function automatic logic [W-1:0] pick_modulus();
    case ($urandom_range(7))
      0: return W'($urandom_range(100, 2));
      1: return '1;
      2: return {1'b1, (W-1)'($urandom)};
      3: return W'(2);
      4: return W'($urandom_range(1));
      default: return W'($urandom);
    endcase
  endfunction

  function automatic logic [W-1:0] pick_exponent();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return W'($urandom_range(20));
      default: return W'($urandom);
    endcase
  endfunction

  function automatic logic [W-1:0] pick_base(logic [W-1:0] n);
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return n - 1'b1;
      3: return n * W'($urandom_range(3));
      4: return W'(1);
      default: return W'($urandom);
    endcase
  endfunction

  // Present one request, after an optional idle gap, and return at the edge that takes it.
  task automatic drive_request(input logic [W-1:0] b, input logic [W-1:0] power);
    int gap;
    if (!steady && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      gap = ($urandom_range(9) == 0) ? $urandom_range(2500, 50) : $urandom_range(6, 1);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    base <= b;
    want_power <= power;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop sending and wait until every outstanding answer has been returned.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (power_due.size() != 0) @(posedge clk);
  endtask

  // Write both registers on consecutive edges; only called with the core idle.
  task automatic program_core(input logic [W-1:0] m, input logic [W-1:0] e);
    cfg_write <= 1'b1;
    cfg_index <= modexp_pkg::REG_MODULUS;
    cfg_data <= m;
    @(posedge clk);
    cfg_index <= modexp_pkg::REG_EXPONENT;
    cfg_data <= e;
    @(posedge clk);
    cfg_write <= 1'b0;
    mod_cfg = m;
    exp_cfg = e;
  endtask

  // Result side: mostly short stalls, now and then a long one while a result waits.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_cycles <= 0;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (!steady && $urandom_range(99) < 17) begin
      out_stall <= 1'b1;
      hold_cycles <= (out_valid && $urandom_range(7) == 0) ?
                     $urandom_range(2500, 50) : $urandom_range(3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Scoreboard: check the returned result first, then queue the answer for a new request.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (power_due.size() == 0) begin
          fault_count++;
          if (fault_count <= REPORT_LIMIT)
            $display("result %h returned with no request outstanding", power_mod);
        end else begin
          if (power_mod !== power_due[0]) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT)
              $display("power_mod mismatch: expected %h, got %h", power_due[0], power_mod);
          end
          void'(power_due.pop_front());
        end
      end
      if (in_valid && !in_stall) power_due.push_back(want_power);
    end
  end

  // Watchdog on cycles in which neither side moves a request.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    int left;
    int count;
    int phase;
    logic [W-1:0] b;

    clk = 1'b0;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = modexp_pkg::REG_MODULUS;
    cfg_data = '0;
    in_valid = 1'b0;
    base = '0;
    want_power = '0;
    mod_cfg = W'(modexp_pkg::MODULUS_RESET);
    exp_cfg = W'(modexp_pkg::EXPONENT_RESET);
    fault_count = 0;
    steady = 1'b0;

    // The first rows run on the settings left by reset.
    probes = '{
      '{32'd17, 32'd6, 32'h0000_0000, 1'b1, 32'd0},
      '{32'd17, 32'd6, 32'h0000_0001, 1'b1, 32'd1},
      '{32'd17, 32'd6, 32'h0000_0002, 1'b1, 32'd13},
      '{32'd17, 32'd6, 32'h0000_0011, 1'b1, 32'd0},
      '{32'd17, 32'd6, 32'hFFFF_FFFF, 1'b1, 32'd0},
      // Zero exponent gives one, even for a zero base.
      '{32'd17, 32'd0, 32'h0000_0005, 1'b1, 32'd1},
      '{32'd17, 32'd0, 32'h0000_0000, 1'b1, 32'd1},
      // Smallest proper modulus.
      '{32'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd1},
      '{32'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b1, 32'd0},
      // A modulus of one leaves only the zero residue.
      '{32'd1, 32'd5, 32'h0000_0007, 1'b1, 32'd0},
      '{32'd1, 32'd0, 32'h0000_0007, 1'b1, 32'd0},
      // A zero modulus yields zero.
      '{32'd0, 32'd5, 32'h0000_0007, 1'b1, 32'd0},
      '{32'd0, 32'd0, 32'hFFFF_FFFF, 1'b1, 32'd0},
      // Largest modulus: the base equal to it reduces to zero, minus one squares to one.
      '{32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 1'b1, 32'd0},
      '{32'hFFFF_FFFF, 32'd1, 32'h0000_0005, 1'b1, 32'd5},
      '{32'hFFFF_FFFF, 32'd2, 32'hFFFF_FFFE, 1'b1, 32'd1},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'd1},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFE},
      // Largest 32-bit prime with exponent p-1: Fermat gives one.
      '{32'hFFFF_FFFB, 32'hFFFF_FFFA, 32'hDEAD_BEEF, 1'b1, 32'd1},
      '{32'h8000_0000, 32'd31, 32'h0000_0002, 1'b0, 32'd0},
      '{32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0003, 1'b0, 32'd0},
      '{32'd12345, 32'h5555_AAAA, 32'hAAAA_5555, 1'b0, 32'd0}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed rows; settings change only once the core has gone idle.
    for (int i = 0; i < DIRECTED; i++) begin
      if (probes[i].modulus != mod_cfg || probes[i].exponent != exp_cfg) begin
        drain();
        program_core(probes[i].modulus, probes[i].exponent);
      end
      drive_request(probes[i].base, probes[i].known ? probes[i].power :
                    modpow(probes[i].base, probes[i].exponent, probes[i].modulus));
    end

    // Random phases, each on fresh settings; one phase runs with no idling on either side.
    left = RANDOM_REQUESTS;
    phase = 0;
    while (left > 0) begin
      drain();
      steady = (phase == 2);
      program_core(pick_modulus(), pick_exponent());
      count = $urandom_range(30, 12);
      if (count > left) count = left;
      repeat (count) begin
        b = pick_base(mod_cfg);
        drive_request(b, modpow(b, exp_cfg, mod_cfg));
      end
      left -= count;
      phase++;
    end

    drain();
    steady = 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fault_count == 0 && power_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/modexp_pkg.sv
hw/rtl/modexp_dp.sv
hw/rtl/modexp_ctrl.sv
hw/rtl/modular_exponentiation.sv
bench/tb_modular_exponentiation.sv
